>>> rtl/mmfn_pkg.sv
// ----------------------------------------------------------------------------
// mmfn_pkg
// Shared types and constants of the min-max feature normalizer.
// ----------------------------------------------------------------------------
package mmfn_pkg;

	localparam int IDX_W       = 10;
	localparam int SAMPLE_W    = 16;
	localparam int SCALED_W    = 17;
	localparam int QUO_W       = SCALED_W - 1;

	// stream widths, tdata rounded up to whole bytes
	localparam int S_TDATA_W   = 32;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 32;
	localparam int M_PAD_W     = M_TDATA_W - IDX_W - SCALED_W;
	localparam int S_PAD_W     = S_TDATA_W - IDX_W - SAMPLE_W;

	localparam logic [SCALED_W-1:0] ONE_Q16  = SCALED_W'(65536);
	localparam logic [SCALED_W-1:0] ZERO_Q16 = '0;

	localparam logic OP_OBSERVE   = 1'b0;
	localparam logic OP_NORMALIZE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

>>> rtl/mmfn_div.sv
// ----------------------------------------------------------------------------
// mmfn_div
// Restoring divider: quo = floor(num * 2^QW / den) for num < den, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmfn_div #(
	parameter int W  = 16,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	output logic          done,
	output logic [QW-1:0] quo
);
	localparam int CW = $clog2(QW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  den_q;
	logic [QW-1:0] quo_q;
	logic [W:0]    rem2;
	logic [W:0]    diff;
	logic          take;

	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign take = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			// remainder stays below den, so the top bit of diff is dropped
			rem_q <= take ? diff[W-1:0] : rem2[W-1:0];
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/min_max_feature_normalizer_unit.sv
// ----------------------------------------------------------------------------
// min_max_feature_normalizer_unit
// Per-feature min/max tracking and Q1.16 min-max scaling over a stream.
// ----------------------------------------------------------------------------
// Observe transfers (tuser operation = 0) update the stored min and max of
// their feature, or load both when first_vector is set; they produce no
// output and are taken one per cycle unless a normalize holds the input;
// the bounds memory is read when the transfer is accepted and written back
// the next cycle, with the write data forwarded to a following transfer on
// the same feature. A normalize returns (sample - min) * 65536 / (max - min)
// on the master side and holds the input until its result is in the output
// register; saturating or zero results skip the 16-step divider, which
// yields one quotient bit per cycle. A finished result waits in the output
// register while the next transfer is taken. Bounds of a feature must be
// loaded by an observe transfer with first_vector set before they are used.
// ----------------------------------------------------------------------------
module min_max_feature_normalizer_unit #(
	parameter int MAX_FEATURES = 1024,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [9:0] feature_index, [25:10] sample_value, rest zero
	input  logic [mmfn_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// [0] operation, [1] first_vector
	input  logic [mmfn_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [9:0] feature_index_out, [26:10] scaled_value, rest zero
	output logic [mmfn_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
	import mmfn_pkg::*;

	localparam int DEPTH = (MAX_FEATURES < (1 << IDX_W)) ? MAX_FEATURES : (1 << IDX_W);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

	state_t state_q;

	logic [2*SW-1:0] bounds_mem_q [DEPTH];

	logic             accept;
	logic             in_op;
	logic             in_first;
	logic [IDX_W-1:0] in_idx;
	logic [SW-1:0]    in_sample;
	logic             in_ok;
	logic [AW-1:0]    in_addr;

	logic             op_s1;
	logic             first_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [SW-1:0]    sample_s1;
	logic             ok_s1;
	logic [2*SW-1:0]  rd_s1;
	logic             fwd_s1;
	logic [2*SW-1:0]  fwd_data_s1;

	logic [2*SW-1:0]  cur;
	logic [SW-1:0]    cur_min;
	logic [SW-1:0]    cur_max;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [2*SW-1:0]  wr_data;
	logic             fwd_hit;

	logic             sat_zero;
	logic             sat_one;
	logic             div_start;
	logic             div_done;
	logic [QUO_W-1:0] div_quo;

	logic [SCALED_W-1:0] res_q;
	logic                out_valid_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [SCALED_W-1:0] out_scaled_q;
	logic                out_load;

	// input decode
	assign in_op     = s_axis_tuser[0];
	assign in_first  = s_axis_tuser[1];
	assign in_idx    = s_axis_tdata[IDX_W-1:0];
	assign in_sample = s_axis_tdata[IDX_W +: SW];
	assign in_ok     = (32'(in_idx) < 32'(MAX_FEATURES));
	assign in_addr   = in_idx[AW-1:0];

	assign s_axis_tready = (state_q == ST_IDLE) ||
		((state_q == ST_CALC) && (op_s1 == OP_OBSERVE));
	assign accept = s_axis_tvalid && s_axis_tready;

	// bounds of the current item, with the write of the previous one forwarded
	assign cur     = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign cur_min = cur[SW-1:0];
	assign cur_max = cur[2*SW-1:SW];

	assign wr_en   = (state_q == ST_CALC) && (op_s1 == OP_OBSERVE) && ok_s1;
	assign wr_addr = idx_s1[AW-1:0];

	always_comb begin
		if (first_s1) begin
			wr_data = {sample_s1, sample_s1};
		end else begin
			wr_data[SW-1:0]    = (sample_s1 < cur_min) ? sample_s1 : cur_min;
			wr_data[2*SW-1:SW] = (sample_s1 > cur_max) ? sample_s1 : cur_max;
		end
	end

	assign fwd_hit = wr_en && (wr_addr == in_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bounds_mem_q[wr_addr] <= wr_data;
		end
		if (accept) begin
			rd_s1 <= bounds_mem_q[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= in_op;
			first_s1    <= in_first;
			idx_s1      <= in_idx;
			sample_s1   <= in_sample;
			ok_s1       <= in_ok;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= wr_data;
		end
	end

	// normalize: special cases settle without the divider
	assign sat_zero  = !ok_s1 || (cur_max <= cur_min) || (sample_s1 <= cur_min);
	assign sat_one   = (sample_s1 >= cur_max);
	assign div_start = (state_q == ST_CALC) && (op_s1 == OP_NORMALIZE) &&
		!sat_zero && !sat_one;

	mmfn_div #(
		.W  (SW),
		.QW (QUO_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sample_s1 - cur_min),
		.den    (cur_max - cur_min),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (op_s1 == OP_OBSERVE) begin
						state_q <= accept ? ST_CALC : ST_IDLE;
					end else if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			res_q <= sat_zero ? ZERO_Q16 : ONE_Q16;
		end else if ((state_q == ST_DIV) && div_done) begin
			res_q <= {1'b0, div_quo};
		end
		if (out_load) begin
			out_idx_q    <= idx_s1;
			out_scaled_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_scaled_q, out_idx_q};

endmodule

>>> rtl/mmfn_checker.sv
// ----------------------------------------------------------------------------
// mmfn_checker
// Port-level checks of the min-max feature normalizer, bound to the top.
// ----------------------------------------------------------------------------
module mmfn_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [mmfn_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import mmfn_pkg::*;

	// a stalled result transfer keeps its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// scaled value never exceeds 1.0
	a_scaled_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[IDX_W +: SCALED_W] <= ONE_Q16))
		else $error("scaled value above 1.0");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:IDX_W+SCALED_W] == '0))
		else $error("tdata padding not zero");

	// a result is loaded only from the output wait, when input is closed
	a_load_closed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared while input was open");

endmodule

bind min_max_feature_normalizer_unit mmfn_checker u_mmfn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
